### rtl/lpfs_pkg.sv
// ----------------------------------------------------------------------------
// lpfs_pkg
// Shared widths, header bit positions and the result word type for the
// length-prefixed frame splitter.
// ----------------------------------------------------------------------------
package lpfs_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 14;  // long-form length field
  localparam int HIGH_W     = 6;   // length bits carried by the first header byte
  localparam int SHORT_BIT  = 6;   // set: short form header
  localparam int COMP_BIT   = 7;   // set: payload compressed

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              compressed;
    logic              first_of_frame;
    logic              last_of_frame;
    logic              empty_frame;
  } res_t;

endpackage

### rtl/lpfs_parser.sv
// ----------------------------------------------------------------------------
// lpfs_parser
// Header decode and payload counter. Consumes one byte per advance strobe and
// produces at most one result word combinationally from the current state and byte.
// ----------------------------------------------------------------------------
module lpfs_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [lpfs_pkg::BYTE_W-1:0]  byte_i,
  output lpfs_pkg::res_t               res_o
);
  import lpfs_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'b001,
    PH_HEAD2 = 3'b010,
    PH_DATA  = 3'b100
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [HIGH_W-1:0] high_len_r, high_len_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic              comp_r, comp_nxt;
  logic              start_r, start_nxt;
  logic [LEN_W-1:0]  len_long;
  logic              last;
  res_t              res;

  assign len_long = {high_len_r, byte_i};
  assign last     = (bytes_left_r <= LEN_W'(1));

  always_comb begin
    phase_nxt      = phase_r;
    high_len_nxt   = high_len_r;
    bytes_left_nxt = bytes_left_r;
    comp_nxt       = comp_r;
    start_nxt      = start_r;
    res            = '0;
    case (phase_r)
      PH_DATA: begin
        res.valid          = 1'b1;
        res.payload_byte   = byte_i;
        res.compressed     = comp_r;
        res.first_of_frame = start_r;
        res.last_of_frame  = last;
        start_nxt          = 1'b0;
        if (last) begin
          bytes_left_nxt = '0;
          phase_nxt      = PH_HEAD;
          start_nxt      = 1'b1;
        end else begin
          bytes_left_nxt = bytes_left_r - LEN_W'(1);
        end
      end
      PH_HEAD2: begin
        start_nxt = 1'b1;
        if (len_long == '0) begin
          bytes_left_nxt  = '0;
          phase_nxt       = PH_HEAD;
          res.valid       = 1'b1;
          res.compressed  = comp_r;
          res.empty_frame = 1'b1;
        end else begin
          bytes_left_nxt = len_long;
          phase_nxt      = PH_DATA;
        end
      end
      default: begin
        // first header byte
        comp_nxt = byte_i[COMP_BIT];
        if (byte_i[SHORT_BIT]) begin
          start_nxt = 1'b1;
          if (byte_i[HIGH_W-1:0] == '0) begin
            bytes_left_nxt  = '0;
            phase_nxt       = PH_HEAD;
            res.valid       = 1'b1;
            res.compressed  = byte_i[COMP_BIT];
            res.empty_frame = 1'b1;
          end else begin
            bytes_left_nxt = {{(LEN_W-HIGH_W){1'b0}}, byte_i[HIGH_W-1:0]};
            phase_nxt      = PH_DATA;
          end
        end else begin
          high_len_nxt = byte_i[HIGH_W-1:0];
          phase_nxt    = PH_HEAD2;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD;
      high_len_r   <= '0;
      bytes_left_r <= '0;
      comp_r       <= 1'b0;
      start_r      <= 1'b1;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      high_len_r   <= high_len_nxt;
      bytes_left_r <= bytes_left_nxt;
      comp_r       <= comp_nxt;
      start_r      <= start_nxt;
    end
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  // payload phase always has at least one byte owed
  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (bytes_left_r != '0))
    else $error("payload phase with zero count");

  // a word that closes a frame leaves the parser expecting a header
  a_close_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.valid && (res.last_of_frame || res.empty_frame)) |=>
      (phase_r == PH_HEAD && start_r))
    else $error("frame close did not return to header");

  // second header byte with no result opens the payload
  a_head2: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && phase_r == PH_HEAD2 && !res.valid) |=> (phase_r == PH_DATA))
    else $error("long header did not open payload");

  // empty-frame word never carries frame marks
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.empty_frame) |->
      (!res.first_of_frame && !res.last_of_frame && res.payload_byte == '0))
    else $error("empty frame word with marks");
`endif

endmodule

### rtl/length_prefixed_frame_splitter.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter: each word passes the input register, a
// single decode stage and the output register. Throughput one byte per cycle
// while out_ready is high. Sync active-low reset, header state.
// ----------------------------------------------------------------------------
module length_prefixed_frame_splitter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpfs_pkg::BYTE_W-1:0] in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpfs_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                        out_compressed,
  output logic                        out_first_of_frame,
  output logic                        out_last_of_frame,
  output logic                        out_empty_frame
);
  import lpfs_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_r;
  res_t              res;
  logic              adv;

  // decode one held word when the output slot is free or draining
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  lpfs_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .byte_i (in_byte_r),
    .res_o  (res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = res.valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (adv && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_compressed     = out_r.compressed;
  assign out_first_of_frame = out_r.first_of_frame;
  assign out_last_of_frame  = out_r.last_of_frame;
  assign out_empty_frame    = out_r.empty_frame;

`ifndef ASSERT_OFF
  // never decode over a stalled result word
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> !(out_valid_r && !out_ready))
    else $error("decode over stalled result");

  // a held word not decoded stays held
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !adv) |=> (in_valid_r && $stable(in_byte_r)))
    else $error("held input word lost");
`endif

endmodule
